@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define BGAS_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define BGAS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bgas_pkg.sv @@
`timescale 1ns / 1ps

package bgas_pkg;

    localparam int MAX_ROW_LENGTH = 1024;
    localparam int MAX_ROWS       = 4096;
    localparam int MIN_DIM        = 3;

    // register field widths
    localparam int LEN_W  = 11;
    localparam int ROWS_W = 13;
    localparam int THR_W  = 4;

    // clamped geometry and position widths
    localparam int LENC_W  = $clog2(MAX_ROW_LENGTH + 1);
    localparam int ROWSC_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W   = $clog2(MAX_ROW_LENGTH);
    localparam int POS_W   = $clog2(MAX_ROW_LENGTH * MAX_ROWS + MAX_ROW_LENGTH + 2);
    localparam int DIV_CNT_W = $clog2(POS_W);

    // stored window columns; the newest column comes straight from the line stores
    localparam int CELL_COUNT = 2;

    // bit 0 top row, bit 2 bottom row
    typedef logic [2:0] column_t;

    typedef enum logic [1:0] {
        REG_ROW_LENGTH = 2'd0,
        REG_ROW_COUNT  = 2'd1,
        REG_BIRTH      = 2'd2,
        REG_DEATH      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/bgas_window_cell.sv @@
`timescale 1ns / 1ps

module bgas_window_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  bgas_pkg::column_t col_in,
    output bgas_pkg::column_t col_out
);
    import bgas_pkg::*;

    column_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

@@ rtl/bgas_line_store.sv @@
`timescale 1ns / 1ps

module bgas_line_store (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [bgas_pkg::COL_W-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [bgas_pkg::COL_W-1:0] wr_addr,
    input  logic                      wr_top,
    input  logic                      wr_mid,
    output logic                      rd_top,
    output logic                      rd_mid
);
    import bgas_pkg::*;

    logic top_mem [0:MAX_ROW_LENGTH-1];
    logic mid_mem [0:MAX_ROW_LENGTH-1];

    logic top_q_reg;
    logic mid_q_reg;
    logic fwd_reg;
    logic fwd_top_reg;
    logic fwd_mid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            top_mem[wr_addr] <= wr_top;
            mid_mem[wr_addr] <= wr_mid;
        end
        if (rd_en) begin
            top_q_reg <= top_mem[rd_addr];
            mid_q_reg <= mid_mem[rd_addr];
        end
    end

    // read and write of the same entry in one cycle: return the new data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_reg     <= wr_en && (wr_addr == rd_addr);
            fwd_top_reg <= wr_top;
            fwd_mid_reg <= wr_mid;
        end
    end

    assign rd_top = fwd_reg ? fwd_top_reg : top_q_reg;
    assign rd_mid = fwd_reg ? fwd_mid_reg : mid_q_reg;

endmodule

@@ rtl/bgas_divider.sv @@
`timescale 1ns / 1ps

module bgas_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bgas_pkg::POS_W-1:0]  dividend,
    input  logic [bgas_pkg::LENC_W-1:0] divisor,
    output bgas_pkg::div_status_t       status,
    output logic [bgas_pkg::POS_W-1:0]  quotient,
    output logic [bgas_pkg::COL_W-1:0]  remainder
);
    import bgas_pkg::*;

    logic [POS_W-1:0]     quo_reg, quo_next;
    logic [LENC_W-1:0]    rem_reg, rem_next;
    logic [LENC_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [LENC_W-1:0]    trial;
    logic                 ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial    = {rem_reg[LENC_W-2:0], quo_reg[POS_W-1]};
        ge       = (trial >= dvs_reg);
        rem_next = ge ? (trial - dvs_reg) : trial;
        quo_next = {quo_reg[POS_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(POS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg[COL_W-1:0];

endmodule

@@ rtl/binary_grid_automaton_smoothing_unit.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One generation of the binary cave-smoothing automaton over a raster stream.
// Each accepted transaction carries one old cell (or a flush item past the grid);
// the block takes one transaction per clock when no recompute or result stall holds
// it, and returns the new value of the cell one row plus one cell behind, so the
// first row_length + 1 transactions of a grid give no result and row_length + 1
// flush transactions close it out. A two-stage pipe (line-store read, then window
// shift and decision) is bounded only by the line stores, which take one read and
// one write per cell in the same cycle. The window is a chain of column cells
// shifted once per transaction. Positions are tracked by counters; after any
// register write the block recomputes them with a shared restoring divider and
// holds s_ready low meanwhile; a further write during the recompute starts it over.
// The line stores need no clearing after reset: entries that were never written
// only reach border cells, which pass unchanged.
module binary_grid_automaton_smoothing_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input cells
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cell_in,
    input  logic        s_grid_start,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_cell_out,
    output logic        m_grid_end,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bgas_pkg::*;

    typedef enum logic [2:0] {
        SEQ_IDLE = 3'b001,
        SEQ_IN   = 3'b010,
        SEQ_OUT  = 3'b100
    } seq_state_t;

    // registers
    logic [LEN_W-1:0]  row_length_reg;
    logic [ROWS_W-1:0] row_count_reg;
    logic [THR_W-1:0]  birth_reg;
    logic [THR_W-1:0]  death_reg;

    // clamped geometry and grid size
    logic [LENC_W-1:0]  len_c;
    logic [ROWSC_W-1:0] rows_c;
    logic [POS_W-1:0]   total_reg;

    // position counters
    logic [POS_W-1:0] in_pos_reg, out_pos_reg, out_row_reg;
    logic [COL_W-1:0] in_col_reg, out_col_reg;

    // position recompute sequencer
    seq_state_t  seq_reg;
    logic        start_reg;
    logic        div_start;
    logic [POS_W-1:0] div_dividend;
    div_status_t div_status;
    logic [POS_W-1:0] div_quotient;
    logic [COL_W-1:0] div_remainder;
    logic        busy;

    // first stage: line-store read in flight
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_bit_reg;
    logic             s1_emit_reg;
    logic             s1_border_reg;
    logic             s1_last_reg;

    // per-transaction decode
    logic [POS_W-1:0] ip, op, orow;
    logic [COL_W-1:0] icol, ocol;
    logic             active, emit, cell_bit, border, last;
    logic             icol_wrap, ocol_wrap;
    logic             accept, take, move;

    // window and decision
    logic    ls_top, ls_mid;
    column_t win_col [0:CELL_COUNT];
    logic    center;
    logic [3:0] ncount;
    logic    res;

    logic cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= LEN_W'(64);
            row_count_reg  <= ROWS_W'(64);
            birth_reg      <= THR_W'(4);
            death_reg      <= THR_W'(4);
        end else if (cfg_wr) begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_ROW_LENGTH: row_length_reg <= pwdata[LEN_W-1:0];
                REG_ROW_COUNT:  row_count_reg  <= pwdata[ROWS_W-1:0];
                REG_BIRTH:      birth_reg      <= pwdata[THR_W-1:0];
                REG_DEATH:      death_reg      <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index_t'(paddr[3:2]))
            REG_ROW_LENGTH: prdata = 32'(row_length_reg);
            REG_ROW_COUNT:  prdata = 32'(row_count_reg);
            REG_BIRTH:      prdata = 32'(birth_reg);
            REG_DEATH:      prdata = 32'(death_reg);
            default:        prdata = '0;
        endcase
    end

    // geometry clamped to the supported range
    always_comb begin
        if (32'(row_length_reg) < MIN_DIM) begin
            len_c = LENC_W'(MIN_DIM);
        end else if (32'(row_length_reg) > MAX_ROW_LENGTH) begin
            len_c = LENC_W'(MAX_ROW_LENGTH);
        end else begin
            len_c = LENC_W'(row_length_reg);
        end
        if (32'(row_count_reg) < MIN_DIM) begin
            rows_c = ROWSC_W'(MIN_DIM);
        end else if (32'(row_count_reg) > MAX_ROWS) begin
            rows_c = ROWSC_W'(MAX_ROWS);
        end else begin
            rows_c = ROWSC_W'(row_count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= POS_W'(len_c) * POS_W'(rows_c);
    end

    // ---------------- position recompute after a register write ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b0;
            seq_reg   <= SEQ_IDLE;
        end else begin
            start_reg <= cfg_wr;
            // a new write restarts the recompute from the input pass
            if (start_reg) begin
                seq_reg <= SEQ_IN;
            end else begin
                unique case (seq_reg)
                    SEQ_IDLE: seq_reg <= SEQ_IDLE;
                    SEQ_IN:   if (div_status.done) seq_reg <= SEQ_OUT;
                    SEQ_OUT:  if (div_status.done) seq_reg <= SEQ_IDLE;
                    default:  seq_reg <= SEQ_IDLE;
                endcase
            end
        end
    end

    // first pass divides the input position, second the output position
    assign div_start    = start_reg || (seq_reg == SEQ_IN && div_status.done);
    assign div_dividend = (seq_reg == SEQ_IN && !start_reg) ? out_pos_reg : in_pos_reg;
    assign busy         = start_reg || (seq_reg != SEQ_IDLE);

    bgas_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (len_c),
        .status    (div_status),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // ---------------- handshake ----------------
    assign move    = s1_valid_reg && (!m_valid || m_ready);
    assign s_ready = !busy && (!s1_valid_reg || move);
    assign accept  = s_valid && s_ready;
    assign take    = accept && active;

    // ---------------- transaction decode ----------------
    always_comb begin
        // grid start restarts both position counters
        ip   = s_grid_start ? '0 : in_pos_reg;
        op   = s_grid_start ? '0 : out_pos_reg;
        orow = s_grid_start ? '0 : out_row_reg;
        icol = s_grid_start ? '0 : in_col_reg;
        ocol = s_grid_start ? '0 : out_col_reg;

        // grid finished: transaction is dropped without effect
        active   = (op < total_reg);
        // flush items shift in an open cell
        cell_bit = (ip < total_reg) ? s_cell_in : 1'b0;
        // warm-up of one row plus one cell
        emit     = (ip >= (POS_W'(len_c) + 1'b1));

        icol_wrap = ((LENC_W'(icol) + LENC_W'(1)) >= len_c);
        ocol_wrap = ((LENC_W'(ocol) + LENC_W'(1)) >= len_c);

        border = (orow == '0) || (orow == (POS_W'(rows_c) - 1'b1)) ||
                 (ocol == '0) || (ocol == COL_W'(len_c - 1'b1));
        last   = (op == (total_reg - 1'b1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_pos_reg  <= '0;
            out_pos_reg <= '0;
            out_row_reg <= '0;
            in_col_reg  <= '0;
            out_col_reg <= '0;
        end else if (take) begin
            in_pos_reg <= ip + 1'b1;
            in_col_reg <= icol_wrap ? '0 : icol + 1'b1;
            if (emit) begin
                out_pos_reg <= op + 1'b1;
                out_col_reg <= ocol_wrap ? '0 : ocol + 1'b1;
                out_row_reg <= ocol_wrap ? orow + 1'b1 : orow;
            end else begin
                out_pos_reg <= op;
                out_col_reg <= ocol;
                out_row_reg <= orow;
            end
        end else if (div_status.done) begin
            if (seq_reg == SEQ_IN) begin
                in_col_reg <= div_remainder;
            end else begin
                out_col_reg <= div_remainder;
                out_row_reg <= div_quotient;
            end
        end
    end

    // ---------------- first stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (take) begin
            s1_valid_reg <= 1'b1;
        end else if (move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_col_reg    <= icol;
            s1_bit_reg    <= cell_bit;
            s1_emit_reg   <= emit;
            s1_border_reg <= border;
            s1_last_reg   <= last;
        end
    end

    // two previous rows; the middle row moves up as the new cell lands
    bgas_line_store u_line_store (
        .aclk    (aclk),
        .rd_en   (take),
        .rd_addr (icol),
        .wr_en   (move),
        .wr_addr (s1_col_reg),
        .wr_top  (ls_mid),
        .wr_mid  (s1_bit_reg),
        .rd_top  (ls_top),
        .rd_mid  (ls_mid)
    );

    // ---------------- window: chain of column cells ----------------
    // win_col[0] left, win_col[CELL_COUNT] the incoming column, all after the shift
    assign win_col[CELL_COUNT] = {s1_bit_reg, ls_mid, ls_top};

    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
        bgas_window_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (move),
            .col_in   (win_col[i+1]),
            .col_out  (win_col[i])
        );
    end

    // ---------------- neighbour count and rule ----------------
    always_comb begin
        center = win_col[1][1];
        ncount = 4'(win_col[0][0]) + 4'(win_col[0][1]) + 4'(win_col[0][2]) +
                 4'(win_col[1][0]) + 4'(win_col[1][2]) +
                 4'(win_col[2][0]) + 4'(win_col[2][1]) + 4'(win_col[2][2]);
        if (s1_border_reg) begin
            res = center;
        end else if (center) begin
            res = !(ncount < death_reg);
        end else begin
            res = (ncount > birth_reg);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (move && s1_emit_reg) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move && s1_emit_reg) begin
            m_cell_out <= res;
            m_grid_end <= s1_last_reg;
        end
    end

    // ---------------- assertions ----------------
    `BGAS_ASSERT_CLK(a_out_behind_in, aclk, aresetn,
        (out_pos_reg <= in_pos_reg), "output position ran ahead of input position")
    `BGAS_ASSERT_CLK(a_col_in_range, aclk, aresetn,
        ((seq_reg == SEQ_IDLE && !start_reg) |-> (LENC_W'(in_col_reg) < len_c)),
        "input column outside the row")
    `BGAS_ASSERT_CLK(a_div_done_seq, aclk, aresetn,
        (div_status.done |-> (seq_reg != SEQ_IDLE)),
        "divider finished with no recompute pending")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import bgas_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned RANDOM_CELLS   = 150;

    typedef struct packed {
        logic cell_out;
        logic grid_end;
    } cell_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_cell_in;
    logic        s_grid_start;
    logic        m_valid;
    logic        m_ready;
    logic        m_cell_out;
    logic        m_grid_end;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the line stores, the 3x3 stencil and the raster counters
    bit                stencil_rows [0:2*MAX_ROW_LENGTH-1];
    logic [8:0]        stencil;
    int unsigned       fed_count;
    int unsigned       emitted_count;

    // predictor copy of the registers
    logic [LEN_W-1:0]  rule_len;
    logic [ROWS_W-1:0] rule_rows;
    logic [THR_W-1:0]  rule_birth;
    logic [THR_W-1:0]  rule_death;

    cell_result_t      expected_cells [$];
    cell_result_t      oldest;
    int unsigned       error_count;
    int unsigned       quiet_cycles;
    int unsigned       grid_cells_sent;
    bit                source_gaps;
    bit                sink_stalls;

    binary_grid_automaton_smoothing_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_in    (s_cell_in),
        .s_grid_start (s_grid_start),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_out   (m_cell_out),
        .m_grid_end   (m_grid_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned grid_size();
        return clamp_dim(32'(rule_len), MAX_ROW_LENGTH) * clamp_dim(32'(rule_rows), MAX_ROWS);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic wall_cell(input int unsigned density);
        return $urandom_range(0, 99) < density;
    endfunction

    // thresholds mostly in the useful band, sometimes anywhere in the field
    function automatic int unsigned pick_threshold();
        if ($urandom_range(0, 9) < 7) return $urandom_range(2, 6);
        return $urandom_range(0, 15);
    endfunction

    // one generation step: shift the old cell in, emit the cell one row plus one behind
    function automatic void predict_generation(input logic old_cell, input logic start);
        int unsigned  len, rows, total, p, col, q, qr, qc, cnt;
        logic         new_cell, top, mid, center, next_cell;
        cell_result_t outcome;
        len   = clamp_dim(32'(rule_len), MAX_ROW_LENGTH);
        rows  = clamp_dim(32'(rule_rows), MAX_ROWS);
        total = len * rows;
        if (start) begin
            fed_count     = 0;
            emitted_count = 0;
        end
        // grid already closed out: nothing moves until the next grid start
        if (emitted_count >= total) return;
        p        = fed_count;
        new_cell = (p < total) ? old_cell : 1'b0;
        col      = p % len;
        top      = stencil_rows[col];
        mid      = stencil_rows[MAX_ROW_LENGTH + col];
        stencil_rows[col]                  = mid;
        stencil_rows[MAX_ROW_LENGTH + col] = new_cell;
        stencil   = {new_cell, stencil[8:7], mid, stencil[5:4], top, stencil[2:1]};
        fed_count = p + 1;
        // warm-up: window not yet filled
        if (p < len + 1) return;
        q         = emitted_count;
        qr        = q / len;
        qc        = q % len;
        center    = stencil[4];
        next_cell = center;
        if (qr != 0 && qr != rows - 1 && qc != 0 && qc != len - 1) begin
            cnt = $countones(stencil & 9'h1EF);
            if (center && cnt < rule_death) next_cell = 1'b0;
            if (!center && cnt > rule_birth) next_cell = 1'b1;
        end
        outcome.cell_out = next_cell;
        outcome.grid_end = (q == total - 1);
        expected_cells.push_back(outcome);
        emitted_count = q + 1;
    endfunction

    // present one cell, hold it until taken, then predict what it causes
    task automatic send_cell(input logic old_cell, input logic start);
        int unsigned gap;
        gap = source_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cell_in    <= old_cell;
        s_grid_start <= start;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_generation(old_cell, start);
    endtask

    // stop feeding and wait until every expected transaction is back and the pipe is quiet
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // setup phase, access phase, then idle; bits above the field are junk
    task automatic write_reg(input reg_index_t idx, input int unsigned value);
        logic [31:0] data;
        data = $urandom;
        case (idx)
            REG_ROW_LENGTH: begin
                data[LEN_W-1:0] = value[LEN_W-1:0];
                rule_len        = value[LEN_W-1:0];
            end
            REG_ROW_COUNT: begin
                data[ROWS_W-1:0] = value[ROWS_W-1:0];
                rule_rows        = value[ROWS_W-1:0];
            end
            REG_BIRTH: begin
                data[THR_W-1:0] = value[THR_W-1:0];
                rule_birth      = value[THR_W-1:0];
            end
            REG_DEATH: begin
                data[THR_W-1:0] = value[THR_W-1:0];
                rule_death      = value[THR_W-1:0];
            end
            default: ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_rule(input int unsigned len, input int unsigned rows,
                            input int unsigned birth, input int unsigned death);
        drain_results();
        write_reg(REG_ROW_LENGTH, len);
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_BIRTH, birth);
        write_reg(REG_DEATH, death);
    endtask

    // feed cells until the grid is closed out; flush cells carry junk
    task automatic run_grid(input int unsigned density, input int unsigned restart_at,
                            input logic fresh);
        int unsigned n;
        send_cell(wall_cell(density), fresh);
        n = 1;
        while (emitted_count < grid_size()) begin
            send_cell(wall_cell(density), n == restart_at);
            n++;
        end
        grid_cells_sent += n;
    endtask

    // reset geometry, then a grid start in the middle of the first grid
    task automatic test_reset_geometry_restart();
        for (int seg = 0; seg < 2; seg++) begin
            send_cell(wall_cell(45), 1'b1);
            repeat (67) send_cell(wall_cell(45), 1'b0);
        end
        drain_results();
    endtask

    // row length above the limit clamps to the widest row; first results follow its warm-up
    task automatic test_widest_row();
        set_rule(2047, 3, 4, 4);
        send_cell(wall_cell(45), 1'b1);
        repeat (1029) send_cell(wall_cell(45), 1'b0);
        drain_results();
    endtask

    // row count above the limit, part of a grid run without idling
    task automatic test_tallest_grid();
        set_rule(3, 8191, 3, 5);
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        send_cell(wall_cell(50), 1'b1);
        repeat (47) send_cell(wall_cell(50), 1'b0);
        drain_results();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // geometry below the minimum clamps to 3x3
    task automatic test_smallest_grids();
        for (int unsigned sz = 0; sz < 4; sz++) begin
            set_rule(sz, sz, 4, 4);
            run_grid(50, 0, 1'b1);
        end
    endtask

    // zero thresholds, full-scale thresholds and values above eight
    task automatic test_threshold_extremes();
        int unsigned births [6]  = '{0, 15, 8, 0, 15, 3};
        int unsigned deaths [6]  = '{0, 15, 9, 15, 0, 5};
        int unsigned density [6] = '{45, 100, 0, 30, 60, 50};
        for (int i = 0; i < 6; i++) begin
            set_rule(5, 4, births[i], deaths[i]);
            run_grid(density[i], 0, 1'b1);
        end
    endtask

    // cells after the grid end are dropped until the next grid start
    task automatic test_finished_grid();
        set_rule(5, 4, 4, 4);
        run_grid(45, 0, 1'b1);
        repeat (4) send_cell(1'($urandom_range(0, 1)), 1'b0);
        run_grid(45, 0, 1'b1);
    endtask

    // geometry rewritten while a grid is half done; the rest follows the new values
    task automatic test_geometry_change();
        set_rule(8, 6, 3, 5);
        send_cell(wall_cell(45), 1'b1);
        repeat (29) send_cell(wall_cell(45), 1'b0);
        drain_results();
        write_reg(REG_ROW_LENGTH, 5);
        write_reg(REG_ROW_COUNT, 7);
        run_grid(45, 0, 1'b0);
    endtask

    // mostly clean grids with random content, some restarts and stray cells
    task automatic test_random_grids();
        int unsigned roll, len, rows, density, restart_at;
        grid_cells_sent = 0;
        while (grid_cells_sent < RANDOM_CELLS) begin
            source_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6) begin
                roll = $urandom_range(0, 9);
                len  = (roll < 8) ? $urandom_range(3, 12) :
                       (roll == 8) ? $urandom_range(0, 2) : $urandom_range(13, 48);
                roll = $urandom_range(0, 19);
                rows = (roll < 17) ? $urandom_range(3, 10) :
                       (roll < 19) ? $urandom_range(0, 2) : $urandom_range(11, 30);
                set_rule(len, rows, pick_threshold(), pick_threshold());
            end
            density    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * 100 :
                         $urandom_range(25, 65);
            restart_at = ($urandom_range(0, 9) == 0) ? $urandom_range(2, grid_size()) : 0;
            run_grid(density, restart_at, 1'b1);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6)) send_cell(1'($urandom_range(0, 1)), 1'b0);
            end
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_cell_in    <= 1'b0;
        s_grid_start <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        stencil       = '0;
        fed_count     = 0;
        emitted_count = 0;
        rule_len      = LEN_W'(64);
        rule_rows     = ROWS_W'(64);
        rule_birth    = THR_W'(4);
        rule_death    = THR_W'(4);
        error_count   = 0;
        source_gaps   = 1'b1;
        sink_stalls   = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_geometry_restart();
        test_widest_row();
        test_tallest_grid();
        test_smallest_grids();
        test_threshold_extremes();
        test_finished_grid();
        test_geometry_change();
        test_random_grids();
        drain_results();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result side back-pressure
    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = sink_stalls ? pick_gap() : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // compare each result transaction with the oldest expected cell
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_cells.size() == 0) begin
                $error("result transaction with nothing expected: cell_out=%0b grid_end=%0b",
                       m_cell_out, m_grid_end);
                error_count++;
            end else begin
                oldest = expected_cells.pop_front();
                if (m_cell_out !== oldest.cell_out) begin
                    $error("cell_out mismatch: expected %0b, actual %0b",
                           oldest.cell_out, m_cell_out);
                    error_count++;
                end
                if (m_grid_end !== oldest.grid_end) begin
                    $error("grid_end mismatch: expected %0b, actual %0b",
                           oldest.grid_end, m_grid_end);
                    error_count++;
                end
            end
        end
    end

    // hang detection: too long without any transaction or register access
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

endmodule
